>>> src/kwm_pkg.sv
package kwm_pkg;

  localparam int LISTS = 8;
  localparam int DEPTH = 64;

  localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = $clog2(LISTS * DEPTH);
  localparam int TW = $clog2(LISTS * DEPTH + 1);
  localparam int PW = 2 * CW;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic clr;
    logic app_rd;
    logic app_wr;
    logic scan;
    logic pop_upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

>>> src/kwm_ram.sv
module kwm_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                   wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                   rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/kwm_ctrl.sv
module kwm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  output logic          in_ready,
  input  kwm_pkg::sts_t sts,
  output kwm_pkg::cmd_t cmd
);
  import kwm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_APP_RD = 6'b000010,
    S_APP_WR = 6'b000100,
    S_SCAN   = 6'b001000,
    S_UPD    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_func)
            FUNC_APPEND: state_nxt = S_APP_RD;
            FUNC_POP:    state_nxt = S_SCAN;
            FUNC_CLEAR: begin
              cmd.clr   = 1'b1;
              state_nxt = S_DONE;
            end
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_APP_RD: begin
        cmd.app_rd = 1'b1;
        state_nxt  = S_APP_WR;
      end
      S_APP_WR: begin
        cmd.app_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.pop_upd = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/kwm_dp.sv
module kwm_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  kwm_pkg::cmd_t cmd,
  output kwm_pkg::sts_t sts,
  input  logic [2:0]    in_list_id,
  input  logic [31:0]   in_value,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [31:0]   out_value,
  output logic [2:0]    out_source_list,
  output logic [1:0]    out_status,
  output logic          out_last
);
  import kwm_pkg::*;

  function automatic logic [MW-1:0] elem_addr(input logic [LW-1:0] l, input logic [CW-1:0] h);
    return MW'(MW'(l) * MW'(DEPTH) + MW'(h));
  endfunction

  logic [2:0]       op_id_r;
  logic [31:0]      op_val_r;
  logic [LISTS-1:0] ptr_vld_r;
  logic             rd_vld_r;
  logic [LW:0]      iss_cnt_r;
  logic             p1_v_r;
  logic [LW-1:0]    p1_idx_r;
  logic             p2_v_r;
  logic [LW-1:0]    p2_idx_r;
  logic             p2_ne_r;
  logic [CW-1:0]    p2_head_r;
  logic [CW-1:0]    p2_tail_r;
  logic             found_r;
  logic [LW-1:0]    best_idx_r;
  logic [CW-1:0]    best_head_r;
  logic [CW-1:0]    best_tail_r;
  logic [31:0]      best_val_r;
  logic [TW-1:0]    total_r;
  logic [31:0]      res_value_r;
  logic [2:0]       res_src_r;
  logic [1:0]       res_status_r;
  logic             res_last_r;
  logic             out_valid_r;
  logic [31:0]      out_value_r;
  logic [2:0]       out_src_r;
  logic [1:0]       out_status_r;
  logic             out_last_r;

  logic             ptr_we;
  logic [LW-1:0]    ptr_waddr;
  logic [PW-1:0]    ptr_wdata;
  logic [LW-1:0]    ptr_raddr;
  logic [PW-1:0]    ptr_q;
  logic [PW-1:0]    ptr_rd;
  logic [CW-1:0]    rd_head;
  logic [CW-1:0]    rd_tail;
  logic             elem_we;
  logic [MW-1:0]    elem_waddr;
  logic [MW-1:0]    elem_raddr;
  logic [31:0]      elem_q;
  logic             id_ok;
  logic             app_ok;
  logic             issue;
  logic             take;
  logic [CW-1:0]    nxt_head;

  assign ptr_rd  = rd_vld_r ? ptr_q : '0;
  assign rd_head = ptr_rd[PW-1:CW];
  assign rd_tail = ptr_rd[CW-1:0];

  assign id_ok    = (32'(op_id_r) < LISTS);
  assign app_ok   = id_ok && (rd_tail < CW'(DEPTH));
  assign issue    = cmd.scan && (iss_cnt_r < (LW+1)'(LISTS));
  assign take     = cmd.scan && p2_v_r && p2_ne_r &&
                    (!found_r || ($signed(elem_q) <= $signed(best_val_r)));
  assign nxt_head = CW'(best_head_r + 1'b1);

  assign ptr_raddr  = cmd.app_rd ? LW'(op_id_r) : iss_cnt_r[LW-1:0];
  assign ptr_we     = (cmd.app_wr && app_ok) || (cmd.pop_upd && found_r);
  assign ptr_waddr  = cmd.pop_upd ? best_idx_r : LW'(op_id_r);
  assign elem_we    = cmd.app_wr && app_ok;
  assign elem_waddr = elem_addr(LW'(op_id_r), rd_tail);
  assign elem_raddr = elem_addr(p1_idx_r, rd_head);

  always_comb begin
    if (cmd.pop_upd) begin
      ptr_wdata = (nxt_head >= best_tail_r) ? '0 : {nxt_head, best_tail_r};
    end else begin
      ptr_wdata = {rd_head, CW'(rd_tail + 1'b1)};
    end
  end

  assign sts.scan_done = cmd.scan && p2_v_r && (p2_idx_r == LW'(LISTS - 1));
  assign sts.out_free  = !out_valid_r || out_ready;

  kwm_ram #(.W(PW), .D(LISTS)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .raddr (ptr_raddr),
    .rdata (ptr_q)
  );

  kwm_ram #(.W(32), .D(LISTS * DEPTH)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (op_val_r),
    .raddr (elem_raddr),
    .rdata (elem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      iss_cnt_r   <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      found_r     <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= ptr_vld_r[ptr_raddr];
      p1_v_r   <= issue;
      p2_v_r   <= cmd.scan && p1_v_r;
      if (issue) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
      end
      if (take) begin
        found_r <= 1'b1;
      end
      if (ptr_we) begin
        ptr_vld_r[ptr_waddr] <= 1'b1;
      end
      if (cmd.accept) begin
        iss_cnt_r <= '0;
        found_r   <= 1'b0;
      end
      if (cmd.clr) begin
        ptr_vld_r <= '0;
        total_r   <= '0;
      end
      if (cmd.app_wr && app_ok) begin
        total_r <= TW'(total_r + 1'b1);
      end
      if (cmd.pop_upd && found_r && (total_r != '0)) begin
        total_r <= TW'(total_r - 1'b1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r  <= iss_cnt_r[LW-1:0];
    p2_idx_r  <= p1_idx_r;
    p2_ne_r   <= (rd_head < rd_tail);
    p2_head_r <= rd_head;
    p2_tail_r <= rd_tail;
    if (take) begin
      best_idx_r  <= p2_idx_r;
      best_head_r <= p2_head_r;
      best_tail_r <= p2_tail_r;
      best_val_r  <= elem_q;
    end
    if (cmd.accept) begin
      op_id_r      <= in_list_id;
      op_val_r     <= in_value;
      res_value_r  <= '0;
      res_src_r    <= '0;
      res_status_r <= ST_OK;
      res_last_r   <= 1'b0;
    end
    if (cmd.app_wr && !app_ok) begin
      res_status_r <= ST_FULL;
    end
    if (cmd.pop_upd) begin
      if (!found_r) begin
        res_status_r <= ST_EMPTY;
      end else begin
        res_value_r <= best_val_r;
        res_src_r   <= 3'(best_idx_r);
        res_last_r  <= (total_r <= TW'(1));
      end
    end
    if (cmd.load_out) begin
      out_value_r  <= res_value_r;
      out_src_r    <= res_src_r;
      out_status_r <= res_status_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_source_list = out_src_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

endmodule

>>> src/k_way_merge_engine_core.sv
// channel   ports                                       handshake
// in        in_func, in_list_id, in_value               in_valid / in_ready
// out       out_value, out_source_list, out_status,     out_valid / out_ready
//           out_last
//
// One request at a time. Append: pointer memory read, element write.
// Pop: a scan of one list head per cycle through the pointer and element
// memories.
// Reset is synchronous, active low; no clearing pass is needed.
// A result waiting on out_ready holds the next result back, not the next accept.
module k_way_merge_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_list_id,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [2:0]  out_source_list,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import kwm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kwm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_list_id      (in_list_id),
    .in_value        (in_value),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_source_list (out_source_list),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

>>> verif/tb_k_way_merge_engine_core.sv
module tb_k_way_merge_engine_core;
  import kwm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int N_RANDOM = 1600;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int SEND_IDLE [3] = '{16, 82, 0};
  localparam int RECV_IDLE [3] = '{82, 16, 0};

  typedef struct {
    logic [1:0]  func;
    logic [2:0]  list_id;
    logic [31:0] value;
    int          phase;
    bit          drain;
  } request_t;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  src;
    status_t     status;
    logic        last;
  } merge_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = FUNC_APPEND;
  logic [2:0]  in_list_id = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_value;
  logic [2:0]  out_source_list;
  logic [1:0]  out_status;
  logic        out_last;

  request_t      pending_requests[$];
  merge_result_t expected_results[$];

  logic [31:0] list_mem [LISTS][DEPTH];
  int          head_ptr [LISTS];
  int          tail_ptr [LISTS];
  int          stored_total;

  int  tx_phase = 0;
  int  err_count = 0;
  int  stall_cycles = 0;
  int  n_accepted = 0;
  int  n_pop_ok = 0;
  int  n_pop_empty = 0;
  int  n_refused = 0;
  int  n_drained = 0;
  int  n_clears = 0;
  int  n_generated = 0;
  bit  hold_next = 1'b0;

  k_way_merge_engine_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_list_id      (in_list_id),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_source_list (out_source_list),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic merge_result_t predict_merge(logic [1:0] f, logic [2:0] id,
                                                  logic [31:0] v);
    merge_result_t r;
    int best;
    bit found;
    logic [31:0] best_val;
    r.value = '0;
    r.src = '0;
    r.status = ST_OK;
    r.last = 1'b0;
    found = 1'b0;
    best = 0;
    best_val = '0;
    case (f)
      FUNC_APPEND: begin
        if (int'(id) >= LISTS || tail_ptr[id] >= DEPTH) begin
          r.status = ST_FULL;
          n_refused++;
        end else begin
          list_mem[id][tail_ptr[id]] = v;
          tail_ptr[id]++;
          stored_total++;
        end
      end
      FUNC_POP: begin
        for (int i = 0; i < LISTS; i++) begin
          if (head_ptr[i] < tail_ptr[i]) begin
            if (!found || $signed(list_mem[i][head_ptr[i]]) <= $signed(best_val)) begin
              found = 1'b1;
              best = i;
              best_val = list_mem[i][head_ptr[i]];
            end
          end
        end
        if (!found) begin
          r.status = ST_EMPTY;
          n_pop_empty++;
        end else begin
          r.value = best_val;
          r.src = best[2:0];
          head_ptr[best]++;
          if (head_ptr[best] >= tail_ptr[best]) begin
            head_ptr[best] = 0;
            tail_ptr[best] = 0;
          end
          if (stored_total > 0) stored_total--;
          r.last = (stored_total == 0);
          n_pop_ok++;
          if (r.last) n_drained++;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < LISTS; i++) begin
          head_ptr[i] = 0;
          tail_ptr[i] = 0;
        end
        stored_total = 0;
        n_clears++;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < 40)
      $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
               n_pop_ok + n_pop_empty);
    err_count++;
  endtask

  task automatic push_req(logic [1:0] f, logic [2:0] id, logic [31:0] v);
    request_t r;
    r.func = f;
    r.list_id = id;
    r.value = v;
    r.phase = 0;
    r.drain = hold_next;
    hold_next = 1'b0;
    pending_requests.push_back(r);
    if (f != FUNC_UNUSED) n_generated++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5, 6: return 32'(int'($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    request_t nxt;
    bit go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_merge(in_func, in_list_id, in_value));
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        go = 1'b0;
        if (pending_requests.size() != 0) begin
          nxt = pending_requests[0];
          go = !(nxt.drain && expected_results.size() != 0) &&
               ($urandom_range(99) >= SEND_IDLE[nxt.phase]);
        end
        if (go) begin
          void'(pending_requests.pop_front());
          in_valid <= 1'b1;
          in_func <= nxt.func;
          in_list_id <= nxt.list_id;
          in_value <= nxt.value;
          tx_phase <= nxt.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    merge_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, value", out_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_value !== want.value) report_mismatch("value", out_value, want.value);
          if (out_source_list !== want.src)
            report_mismatch("source_list", 32'(out_source_list), 32'(want.src));
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_last !== want.last)
            report_mismatch("last", 32'(out_last), 32'(want.last));
        end
      end
      out_ready <= ($urandom_range(99) >= RECV_IDLE[tx_phase]);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", stall_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int base;
    int step;
    int id;
    int total;
    logic [31:0] v;

    for (int i = 0; i < LISTS; i++) begin
      head_ptr[i] = 0;
      tail_ptr[i] = 0;
    end
    stored_total = 0;

    push_req(FUNC_APPEND, 3'd0, 32'h8000_0000);
    push_req(FUNC_APPEND, 3'd7, 32'h7fff_ffff);
    push_req(FUNC_APPEND, 3'd3, 32'h0000_0000);
    push_req(FUNC_APPEND, 3'd5, 32'hffff_ffff);
    push_req(FUNC_APPEND, 3'd2, 32'd5);
    push_req(FUNC_APPEND, 3'd6, 32'd5);
    push_req(FUNC_APPEND, 3'd4, 32'd5);
    for (int i = 0; i < 8; i++) push_req(FUNC_POP, 3'd0, 32'h0);
    push_req(FUNC_UNUSED, 3'd7, 32'hffff_ffff);
    push_req(FUNC_APPEND, 3'd1, 32'h5555_5555);
    push_req(FUNC_APPEND, 3'd1, 32'haaaa_aaaa);
    push_req(FUNC_CLEAR, 3'd0, 32'h0);
    push_req(FUNC_POP, 3'd7, 32'hffff_ffff);
    push_req(FUNC_APPEND, 3'd0, 32'hffff_ffff);
    push_req(FUNC_POP, 3'd0, 32'h0);

    n_generated = 0;
    while (n_generated < N_RANDOM) begin
      hold_next = ($urandom_range(19) == 0);
      case ($urandom_range(9))
        0, 1, 2: begin
          total = 0;
          for (int l = 0; l < LISTS; l++) begin
            if ($urandom_range(1)) begin
              n = $urandom_range(1, 8);
              base = ($urandom_range(7) == 0) ? int'($urandom) : int'($urandom_range(2000)) - 1000;
              for (int k = 0; k < n; k++) begin
                push_req(FUNC_APPEND, 3'(l), 32'(base));
                step = $urandom_range(3);
                base = base + step;
              end
              total += n;
            end
          end
          for (int k = 0; k < total + int'($urandom_range(1)); k++)
            push_req(FUNC_POP, 3'($urandom), $urandom);
        end
        3, 4: begin
          n = $urandom_range(1, 10);
          for (int k = 0; k < n; k++) push_req(FUNC_APPEND, 3'($urandom), pick_value());
          for (int k = 0; k < int'($urandom_range(n + 1)); k++)
            push_req(FUNC_POP, 3'($urandom), $urandom);
        end
        5: begin
          id = $urandom_range(LISTS - 1);
          for (int k = 0; k < DEPTH + int'($urandom_range(1, 3)); k++)
            push_req(FUNC_APPEND, 3'(id), pick_value());
          for (int k = 0; k < int'($urandom_range(10)); k++)
            push_req(FUNC_POP, 3'($urandom), $urandom);
          push_req(FUNC_CLEAR, 3'($urandom), $urandom);
        end
        6: begin
          push_req(FUNC_CLEAR, 3'($urandom), $urandom);
          if ($urandom_range(1)) push_req(FUNC_POP, 3'($urandom), $urandom);
        end
        7, 8: begin
          for (int k = 0; k < 6; k++) begin
            if ($urandom_range(2) == 0) push_req(FUNC_POP, 3'($urandom), $urandom);
            else push_req(FUNC_APPEND, 3'($urandom), pick_value());
          end
        end
        default: begin
          v = $urandom;
          push_req(2'($urandom_range(3)), 3'($urandom), v);
        end
      endcase
    end

    foreach (pending_requests[i]) begin
      pending_requests[i].phase = (i * 3) / pending_requests.size();
      if (i > 0 && pending_requests[i].phase != pending_requests[i - 1].phase)
        pending_requests[i].drain = 1'b1;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d merged pops (%0d emptied the store), %0d empty pops,",
             n_accepted, n_pop_ok, n_drained, n_pop_empty);
    $display("  %0d refused appends, %0d clears, under three idle/stall mixes",
             n_refused, n_clears);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
